/* sv/gipb_pkg.sv */
// Shared types, constants and the microcode table of the gyro-integrating
// balance controller. No dependencies; used by gipb_datapath and the top level.
package gipb_pkg;

  // Default value width, Q16.16 held in this many bits of two's complement.
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_ANGLE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_INT_DT       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV_PER_DT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_DT         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_SAMPLES    = 3'd5;

  localparam logic [31:0] RST_TARGET_ANGLE      = 32'd0;
  localparam logic [31:0] RST_GAIN_PROP         = 32'd327680;
  localparam logic [31:0] RST_GAIN_INT_DT       = 32'd328;
  localparam logic [31:0] RST_GAIN_DERIV_PER_DT = 32'd32768000;
  localparam logic [15:0] RST_PERIOD_DT         = 16'd655;
  localparam logic [15:0] RST_SETTLE_SAMPLES    = 16'd500;

  // Microprogram geometry.
  localparam int unsigned STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_FINISH = 4'd11;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_DT_RATE,
    MUL_P_LO,
    MUL_P_HI,
    MUL_I_LO,
    MUL_I_HI,
    MUL_D_LO,
    MUL_D_HI
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADDHI
  } acc_op_e;

  typedef enum logic [1:0] {
    SUM_HOLD,
    SUM_LOAD,
    SUM_ADD
  } sum_op_e;

  typedef enum logic [1:0] {
    ALU_NONE,
    ALU_TILT,
    ALU_ERR,
    ALU_INTEG
  } alu_op_e;

  typedef enum logic [1:0] {
    SEQ_NEXT,
    SEQ_SKIP_IDLE,
    SEQ_FINISH
  } seq_op_e;

  typedef struct packed {
    mul_sel_e          mul;
    acc_op_e           acc;
    sum_op_e           sum;
    alu_op_e           alu;
    seq_op_e           seq;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  // Control store. Each gain product is formed as low half plus high half
  // shifted by 16, accumulated, then rescaled and summed.
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w = '{mul: MUL_NONE, acc: ACC_HOLD, sum: SUM_HOLD, alu: ALU_NONE,
          seq: SEQ_NEXT, target: '0};
    unique case (step)
      4'd0: begin
        w.mul = MUL_DT_RATE;
      end
      4'd1: begin
        w.alu    = ALU_TILT;
        w.seq    = SEQ_SKIP_IDLE;
        w.target = STEP_FINISH;
      end
      4'd2: begin
        w.alu = ALU_ERR;
      end
      4'd3: begin
        w.alu = ALU_INTEG;
        w.mul = MUL_P_LO;
      end
      4'd4: begin
        w.acc = ACC_LOAD;
        w.mul = MUL_P_HI;
      end
      4'd5: begin
        w.acc = ACC_ADDHI;
        w.mul = MUL_I_LO;
      end
      4'd6: begin
        w.sum = SUM_LOAD;
        w.acc = ACC_LOAD;
        w.mul = MUL_I_HI;
      end
      4'd7: begin
        w.acc = ACC_ADDHI;
        w.mul = MUL_D_LO;
      end
      4'd8: begin
        w.sum = SUM_ADD;
        w.acc = ACC_LOAD;
        w.mul = MUL_D_HI;
      end
      4'd9: begin
        w.acc = ACC_ADDHI;
      end
      4'd10: begin
        w.sum = SUM_ADD;
      end
      default: begin
        w.seq = SEQ_FINISH;
      end
    endcase
    return w;
  endfunction

endpackage

/* sv/gipb_datapath.sv */
// Arithmetic datapath of the balance controller: one shared multiplier,
// accumulator, term sum and the angle/PID state registers. Depends on gipb_pkg.
module gipb_datapath #(
  parameter int unsigned VALUE_WIDTH = gipb_pkg::VALUE_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gipb_pkg::ctrl_t               ctrl_i,
  input  logic                          run_i,
  input  logic                          load_i,
  input  logic                          zero_tilt_i,
  input  logic signed [15:0]            gyro_rate_i,
  input  logic [31:0]                   target_angle_i,
  input  logic [31:0]                   gain_prop_i,
  input  logic [31:0]                   gain_int_dt_i,
  input  logic [31:0]                   gain_deriv_i,
  input  logic [15:0]                   period_dt_i,
  output logic signed [VALUE_WIDTH-1:0] drive_o
);

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned PW = W + 17;  // product of 16-bit unsigned and W-bit signed
  localparam int unsigned SW = W + 34;  // accumulator and saturation input width
  localparam int unsigned UW = W + 2;   // sum of three saturated terms

  localparam logic signed [SW-1:0] VMAX = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SW-1:0] VMIN = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};

  function automatic logic signed [W-1:0] sat_w(input logic signed [SW-1:0] x);
    logic signed [W-1:0] r;
    if (x > VMAX) begin
      r = VMAX[W-1:0];
    end else if (x < VMIN) begin
      r = VMIN[W-1:0];
    end else begin
      r = x[W-1:0];
    end
    return r;
  endfunction

  logic signed [15:0]   rate_q;
  logic signed [W-1:0]  tilt_q, tilt_d;
  logic signed [W-1:0]  integ_q, integ_d;
  logic signed [W-1:0]  last_q, last_d;
  logic signed [W-1:0]  err_q, err_d;
  logic signed [W-1:0]  diff_q, diff_d;
  logic signed [PW-1:0] prod_q, prod_d;
  logic signed [SW-1:0] acc_q, acc_d;
  logic signed [UW-1:0] sum_q, sum_d;

  logic [15:0]          mul_a;
  logic signed [W-1:0]  mul_b;
  logic signed [W-1:0]  target_s;
  logic signed [W-1:0]  term;

  assign target_s = sat_w(SW'($signed(target_angle_i)));
  assign term     = sat_w(acc_q >>> 16);
  assign drive_o  = sat_w(SW'(sum_q));

  always_comb begin
    unique case (ctrl_i.mul)
      gipb_pkg::MUL_NONE: begin
        mul_a = '0;
        mul_b = '0;
      end
      gipb_pkg::MUL_DT_RATE: begin
        mul_a = period_dt_i;
        mul_b = W'(rate_q);
      end
      gipb_pkg::MUL_P_LO: begin
        mul_a = gain_prop_i[15:0];
        mul_b = err_q;
      end
      gipb_pkg::MUL_P_HI: begin
        mul_a = gain_prop_i[31:16];
        mul_b = err_q;
      end
      gipb_pkg::MUL_I_LO: begin
        mul_a = gain_int_dt_i[15:0];
        mul_b = integ_q;
      end
      gipb_pkg::MUL_I_HI: begin
        mul_a = gain_int_dt_i[31:16];
        mul_b = integ_q;
      end
      gipb_pkg::MUL_D_LO: begin
        mul_a = gain_deriv_i[15:0];
        mul_b = diff_q;
      end
      gipb_pkg::MUL_D_HI: begin
        mul_a = gain_deriv_i[31:16];
        mul_b = diff_q;
      end
    endcase
  end

  assign prod_d = $signed({1'b0, mul_a}) * mul_b;

  always_comb begin
    tilt_d  = tilt_q;
    integ_d = integ_q;
    last_d  = last_q;
    err_d   = err_q;
    diff_d  = diff_q;
    acc_d   = acc_q;
    sum_d   = sum_q;

    if (zero_tilt_i) begin
      tilt_d = '0;
    end

    if (run_i) begin
      unique case (ctrl_i.alu)
        gipb_pkg::ALU_NONE: begin
        end
        gipb_pkg::ALU_TILT: begin
          // Rate times period is Q8.8 * Q0.16; drop 8 bits to reach Q16.16.
          tilt_d = sat_w(SW'(tilt_q) + SW'(prod_q >>> 8));
        end
        gipb_pkg::ALU_ERR: begin
          err_d = sat_w(SW'(target_s) - SW'(tilt_q));
        end
        gipb_pkg::ALU_INTEG: begin
          integ_d = sat_w(SW'(integ_q) + SW'(err_q));
          diff_d  = sat_w(SW'(err_q) - SW'(last_q));
          last_d  = err_q;
        end
      endcase

      unique case (ctrl_i.acc)
        gipb_pkg::ACC_LOAD:  acc_d = SW'(prod_q);
        gipb_pkg::ACC_ADDHI: acc_d = acc_q + (SW'(prod_q) <<< 16);
        default:             acc_d = acc_q;
      endcase

      unique case (ctrl_i.sum)
        gipb_pkg::SUM_LOAD: sum_d = UW'(term);
        gipb_pkg::SUM_ADD:  sum_d = sum_q + UW'(term);
        default:            sum_d = sum_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tilt_q  <= '0;
      integ_q <= '0;
      last_q  <= '0;
    end else begin
      tilt_q  <= tilt_d;
      integ_q <= integ_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rate_q <= gyro_rate_i;
    end
    prod_q <= prod_d;
    err_q  <= err_d;
    diff_q <= diff_d;
    acc_q  <= acc_d;
    sum_q  <= sum_d;
  end

endmodule

/* sv/gyro_integrate_pid_balance.sv */
// Top level of the gyro-integrating PID balance controller: configuration
// registers, microcode sequencer and result register. Depends on gipb_pkg
// and gipb_datapath.
//
// One gyro rate word in gives one result word out. A word is taken when the
// controller is idle; a settling sample then runs only the angle update, an
// active sample the whole microprogram, and a new word is taken only when the
// previous one is done. This is set by the single shared 16 x VALUE_WIDTH
// multiplier, which forms the angle increment and the six half products of the
// three gain terms in turn under the microprogram. The result sits in an output
// register, so the next word is accepted while a result still waits. The first
// settle_samples words are settling words with zero drive; the next one zeroes
// the angle and starts control. Registers should be written only while idle.
module gyro_integrate_pid_balance #(
  parameter int unsigned VALUE_WIDTH = gipb_pkg::VALUE_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [gipb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [gipb_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [15:0]              gyro_rate_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            active_o,
  output logic signed [31:0]              drive_o,
  output logic                            dir_first_o,
  output logic                            dir_second_o,
  output logic                            step_strobe_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic [31:0] target_q, gain_prop_q, gain_int_q, gain_deriv_q;
  logic [15:0] period_q, settle_q;

  logic                         state_q, state_d;
  logic [gipb_pkg::STEP_W-1:0]  step_q, step_d;
  logic [15:0]                  count_q, count_d;
  logic                         init_q, init_d;
  logic                         out_valid_q, out_valid_d;
  logic                         active_q;
  logic signed [31:0]           drive_q;
  logic                         dir_first_q, dir_second_q;

  gipb_pkg::ctrl_t              ctrl;
  logic                         in_accept;
  logic                         run;
  logic                         zero_tilt;
  logic                         finish;
  logic                         out_free;
  logic signed [VALUE_WIDTH-1:0] drive_w;

  assign ctrl      = gipb_pkg::ucode(step_q);
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_accept = in_valid_i && in_ready_o;
  assign run       = (state_q == ST_RUN);
  assign out_free  = !out_valid_q || out_ready_i;
  assign finish    = run && (ctrl.seq == gipb_pkg::SEQ_FINISH) && out_free;
  assign zero_tilt = in_accept && !init_q && (count_q >= settle_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q     <= gipb_pkg::RST_TARGET_ANGLE;
      gain_prop_q  <= gipb_pkg::RST_GAIN_PROP;
      gain_int_q   <= gipb_pkg::RST_GAIN_INT_DT;
      gain_deriv_q <= gipb_pkg::RST_GAIN_DERIV_PER_DT;
      period_q     <= gipb_pkg::RST_PERIOD_DT;
      settle_q     <= gipb_pkg::RST_SETTLE_SAMPLES;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gipb_pkg::REG_TARGET_ANGLE:      target_q     <= cfg_wdata_i;
        gipb_pkg::REG_GAIN_PROP:         gain_prop_q  <= cfg_wdata_i;
        gipb_pkg::REG_GAIN_INT_DT:       gain_int_q   <= cfg_wdata_i;
        gipb_pkg::REG_GAIN_DERIV_PER_DT: gain_deriv_q <= cfg_wdata_i;
        gipb_pkg::REG_PERIOD_DT:         period_q     <= cfg_wdata_i[15:0];
        gipb_pkg::REG_SETTLE_SAMPLES:    settle_q     <= cfg_wdata_i[15:0];
        default: begin
        end
      endcase
    end
  end

  // Settling is decided when the word is taken, before the angle update.
  always_comb begin
    count_d = count_q;
    init_d  = init_q;
    if (in_accept && !init_q) begin
      if (count_q >= settle_q) begin
        init_d = 1'b1;
      end else begin
        count_d = count_q + 16'd1;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    if (in_accept) begin
      state_d = ST_RUN;
      step_d  = '0;
    end else if (run) begin
      unique case (ctrl.seq)
        gipb_pkg::SEQ_NEXT: begin
          step_d = step_q + 1'b1;
        end
        gipb_pkg::SEQ_SKIP_IDLE: begin
          step_d = init_q ? step_q + 1'b1 : ctrl.target;
        end
        gipb_pkg::SEQ_FINISH: begin
          if (out_free) begin
            state_d = ST_IDLE;
          end
        end
        default: begin
          state_d = ST_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      count_q     <= '0;
      init_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      count_q     <= count_d;
      init_q      <= init_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      active_q     <= init_q;
      drive_q      <= init_q ? 32'(drive_w) : '0;
      dir_first_q  <= init_q && (drive_w > 0);
      dir_second_q <= init_q && (drive_w < 0);
    end
  end

  gipb_datapath #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .run_i         (run),
    .load_i        (in_accept),
    .zero_tilt_i   (zero_tilt),
    .gyro_rate_i   (gyro_rate_i),
    .target_angle_i(target_q),
    .gain_prop_i   (gain_prop_q),
    .gain_int_dt_i (gain_int_q),
    .gain_deriv_i  (gain_deriv_q),
    .period_dt_i   (period_q),
    .drive_o       (drive_w)
  );

  assign out_valid_o   = out_valid_q;
  assign active_o      = active_q;
  assign drive_o       = drive_q;
  assign dir_first_o   = dir_first_q;
  assign dir_second_o  = dir_second_q;
  assign step_strobe_o = active_q;

endmodule
